// File: hw/rtl/rfid_response_frame_checker_defines.svh
// assertion macros for the rfid response frame checker
`ifndef RFID_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define RFID_RESPONSE_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define RFC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define RFC_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define RFC_ASSERT(label, prop, msg)
`define RFC_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// File: hw/rtl/rfc_pkg.sv
// shared constants, types and functions of the rfid response frame checker
`timescale 1ns / 1ps

package rfc_pkg;

   localparam int BYTE_W   = 8;
   localparam int CRC_W    = 16;
   localparam int TICK_W   = 16;
   localparam int REPLY_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W    = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_PRESET    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   // configuration reset values
   localparam logic [CRC_W-1:0]  CRC_PRESET_RESET    = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY_RESET      = 16'h8408;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RESET = 16'd100;

   // item commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // frame layout and reply codes
   localparam logic [BYTE_W-1:0]  OPCODE_POS      = 8'd2;
   localparam logic [REPLY_W-1:0] REPLY_INVENTORY = 4'd8;
   localparam logic [REPLY_W-1:0] REPLY_NONE      = 4'd0;
   localparam logic [TICK_W-1:0]  IDLE_MAX        = 16'hFFFF;
   localparam int NUM_OPCODES = 9;

   typedef logic [BYTE_W-1:0] opcode_table_type [NUM_OPCODES];

   localparam opcode_table_type OPCODE_TABLE = '{
      8'h21, 8'h22, 8'h24, 8'h25, 8'h28, 8'h2F, 8'h35, 8'h36, 8'h01
   };

   // bytewise reflected crc update, one shift per bit
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // opcode to reply code, first match wins, inventory when none
   function automatic logic [REPLY_W-1:0] lookup_reply(input logic [BYTE_W-1:0] op);
      logic [REPLY_W-1:0] code;
      logic               found;
      code  = REPLY_INVENTORY;
      found = 1'b0;
      for (int i = 0; i < NUM_OPCODES; i++) begin
         if (!found && OPCODE_TABLE[i] == op) begin
            code  = REPLY_W'(i);
            found = 1'b1;
         end
      end
      return code;
   endfunction

endpackage

// File: hw/rtl/rfc_req_if.sv
// request channel of the rfid response frame checker
`timescale 1ns / 1ps

interface rfc_req_if import rfc_pkg::*;;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// File: hw/rtl/rfc_rsp_if.sv
// response channel of the rfid response frame checker
`timescale 1ns / 1ps

interface rfc_rsp_if import rfc_pkg::*;;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic [BYTE_W-1:0]  byte_pos;
   logic               frame_end;
   logic               crc_ok;
   logic [REPLY_W-1:0] reply_code;
   logic               timed_out;

   modport source (output valid, output out_byte, output byte_pos, output frame_end,
                   output crc_ok, output reply_code, output timed_out, input ready);
   modport sink   (input valid, input out_byte, input byte_pos, input frame_end,
                   input crc_ok, input reply_code, input timed_out, output ready);
endinterface

// File: hw/rtl/rfid_response_frame_checker.sv
// top level of the rfid response frame checker
`timescale 1ns / 1ps
`include "rfid_response_frame_checker_defines.svh"

// Checks length-prefixed reader reply frames byte by byte. Each item is either a
// received byte or one timer tick. A nonzero byte outside a frame opens a frame and
// gives the count of bytes that follow; each frame byte comes out with its position,
// and the last one carries frame_end, the CRC-16 residue check (trailing CRC included)
// and a reply code from the byte at position 2. Too many ticks inside a frame abort
// it with a timed_out result. The block takes one item per clock while its result
// register is free: an item sits in an input register, then one CRC byte update and
// the counter logic load the result register, from which the result can be taken.
// While a result waits, the input register keeps its item, so the block holds at
// most two items before it stalls its input. Zero bytes outside a frame and most
// ticks give no result. Configuration writes take effect at once; a new CRC preset
// is used from the next frame start.
module rfid_response_frame_checker import rfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rfc_req_if.sink              req_ch,
   rfc_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // configuration registers
   logic [CRC_W-1:0]  crc_preset_ff;
   logic [CRC_W-1:0]  crc_poly_ff;
   logic [TICK_W-1:0] timeout_ticks_ff;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_cmd_ff;
   logic [BYTE_W-1:0] s1_byte_ff;

   // frame state
   logic              in_frame_ff, in_frame_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0] next_pos_ff, next_pos_in;
   logic [CRC_W-1:0]  crc_reg_ff, crc_reg_in;
   logic [BYTE_W-1:0] opcode_byte_ff, opcode_byte_in;
   logic [TICK_W-1:0] idle_count_ff, idle_count_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic [BYTE_W-1:0]  byte_pos_ff, byte_pos_in;
   logic               frame_end_ff, frame_end_in;
   logic               crc_ok_ff, crc_ok_in;
   logic [REPLY_W-1:0] reply_code_ff, reply_code_in;
   logic               timed_out_ff, timed_out_in;

   logic              out_free;
   logic              s1_take;
   logic              out_load;
   logic              req_fire;
   logic [CRC_W-1:0]  crc_seed;
   logic [CRC_W-1:0]  crc_next;
   logic [TICK_W-1:0] idle_inc;

   // handshake
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_take      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || s1_take;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_take);

   // shared crc update and saturating idle count
   assign crc_seed = in_frame_ff ? crc_reg_ff : crc_preset_ff;
   assign crc_next = crc_byte(crc_seed, s1_byte_ff, crc_poly_ff);
   assign idle_inc = (idle_count_ff == IDLE_MAX) ? idle_count_ff : idle_count_ff + 1'b1;

   // item processing
   always_comb begin
      in_frame_in    = in_frame_ff;
      bytes_left_in  = bytes_left_ff;
      next_pos_in    = next_pos_ff;
      crc_reg_in     = crc_reg_ff;
      opcode_byte_in = opcode_byte_ff;
      idle_count_in  = idle_count_ff;
      out_load       = 1'b0;
      out_byte_in    = s1_byte_ff;
      byte_pos_in    = '0;
      frame_end_in   = 1'b0;
      crc_ok_in      = 1'b0;
      reply_code_in  = REPLY_NONE;
      timed_out_in   = 1'b0;
      if (s1_take) begin
         if (s1_cmd_ff == CMD_TICK) begin
            if (in_frame_ff) begin
               idle_count_in = idle_inc;
               if (idle_inc >= timeout_ticks_ff) begin
                  in_frame_in   = 1'b0;
                  bytes_left_in = '0;
                  next_pos_in   = '0;
                  idle_count_in = '0;
                  out_load      = 1'b1;
                  out_byte_in   = '0;
                  frame_end_in  = 1'b1;
                  timed_out_in  = 1'b1;
               end
            end
         end else if (!in_frame_ff) begin
            // length byte opens a frame
            if (s1_byte_ff != '0) begin
               in_frame_in    = 1'b1;
               bytes_left_in  = s1_byte_ff;
               next_pos_in    = 8'd1;
               opcode_byte_in = '0;
               idle_count_in  = '0;
               crc_reg_in     = crc_next;
               out_load       = 1'b1;
            end
         end else begin
            // byte inside a frame
            crc_reg_in    = crc_next;
            if (next_pos_ff == OPCODE_POS) begin
               opcode_byte_in = s1_byte_ff;
            end
            next_pos_in   = next_pos_ff + 1'b1;
            idle_count_in = '0;
            bytes_left_in = bytes_left_ff - 1'b1;
            out_load      = 1'b1;
            byte_pos_in   = next_pos_ff;
            if (bytes_left_in == '0) begin
               in_frame_in   = 1'b0;
               frame_end_in  = 1'b1;
               crc_ok_in     = (crc_next == '0);
               reply_code_in = lookup_reply(opcode_byte_in);
            end
         end
      end
   end

   assign out_valid_in = out_load || (out_valid_ff && !rsp_ch.ready);

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_preset_ff    <= CRC_PRESET_RESET;
         crc_poly_ff      <= CRC_POLY_RESET;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
         s1_valid_ff      <= 1'b0;
         in_frame_ff      <= 1'b0;
         bytes_left_ff    <= '0;
         next_pos_ff      <= '0;
         crc_reg_ff       <= CRC_PRESET_RESET;
         opcode_byte_ff   <= '0;
         idle_count_ff    <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CRC_PRESET:    crc_preset_ff    <= csr_wdata;
               CSR_CRC_POLY:      crc_poly_ff      <= csr_wdata;
               CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
               default: ;
            endcase
         end
         s1_valid_ff    <= s1_valid_in;
         in_frame_ff    <= in_frame_in;
         bytes_left_ff  <= bytes_left_in;
         next_pos_ff    <= next_pos_in;
         crc_reg_ff     <= crc_reg_in;
         opcode_byte_ff <= opcode_byte_in;
         idle_count_ff  <= idle_count_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= req_ch.cmd;
         s1_byte_ff <= req_ch.rx_byte;
      end
      if (out_load) begin
         out_byte_ff   <= out_byte_in;
         byte_pos_ff   <= byte_pos_in;
         frame_end_ff  <= frame_end_in;
         crc_ok_ff     <= crc_ok_in;
         reply_code_ff <= reply_code_in;
         timed_out_ff  <= timed_out_in;
      end
   end

   // response outputs
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_byte   = out_byte_ff;
   assign rsp_ch.byte_pos   = byte_pos_ff;
   assign rsp_ch.frame_end  = frame_end_ff;
   assign rsp_ch.crc_ok     = crc_ok_ff;
   assign rsp_ch.reply_code = reply_code_ff;
   assign rsp_ch.timed_out  = timed_out_ff;

   // checks
   `RFC_ASSERT(a_frame_len, in_frame_ff == (bytes_left_ff != '0), "frame count mismatch")
   `RFC_ASSERT_NEXT(a_close_result, in_frame_ff && !in_frame_in, out_valid_ff && frame_end_ff, "no end item")
   `RFC_ASSERT_NEXT(a_s1_hold, !req_ch.ready, $stable({s1_valid_ff, s1_cmd_ff, s1_byte_ff}), "item lost")

endmodule
